FILE: sv/repeating_interval_timer_macros.svh
// Assertion macros for the repeating interval timer.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef REPEATING_INTERVAL_TIMER_MACROS_SVH
`define REPEATING_INTERVAL_TIMER_MACROS_SVH

// Same-cycle implication, off during reset.
`define RIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rit assertion failed");

// Next-cycle implication, off during reset.
`define RIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rit assertion failed");

`endif

FILE: sv/rit_pkg.sv
// Package for the repeating interval timer: payload structs, codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rit_pkg;

    localparam logic [1:0] FUNC_POLL  = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_SAMPLES  = 2'd2;

    localparam logic [3:0] SAMPLES_RESET = 4'd10;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic        fired;
        logic [31:0] interval_measured;
        logic [31:0] fire_count;
        logic        running;
        logic [31:0] remaining_ms;
        logic [31:0] average_ms;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/repeating_interval_timer.sv
// Repeating interval timer: millisecond poll/stop/start timer with interval history
// and a running mean. Depends on rit_pkg and repeating_interval_timer_macros.svh.
//
// Usage: one input transfer (i_valid, o_stall, i_data) carries an operation and the
// current millisecond time; each produces exactly one result transfer (o_valid,
// i_stall, o_data). An input transfer takes place when i_valid is high and o_stall
// low; a result transfer when o_valid is high and i_stall low.
// The history sweep reads one entry a cycle from the history RAM, then a restoring
// divider produces one quotient bit a cycle. One item is in work at a time, so no
// new item is taken before the current one has reached the output register.
// The user writes registers through i_cfg_we/i_cfg_idx/i_cfg_data only while idle;
// the block itself does not enforce it.
// The result sits in an output register, so the next item is taken while an
// earlier result still waits; if the receiver stalls for long, the finished item
// waits in the last step until the output register frees up, holding o_stall high.
// Reset (synchronous, active low) stops all work, drops o_valid, sets the timer
// running with reference 0, count 0, interval and limit 0 and 10 samples.
`timescale 1ns / 1ps
`default_nettype none
`include "repeating_interval_timer_macros.svh"

module repeating_interval_timer #(
    parameter int HISTORY_DEPTH = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rit_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output rit_pkg::t_out      o_data
);

    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = 32 + CW;
    localparam int BW = $clog2(SW + 1);

    // configuration
    logic [31:0] r_interval;
    logic [31:0] r_limit;
    logic [3:0]  r_samples;

    // timer state
    logic          r_active,  n_active;
    logic [31:0]   r_ref,     n_ref;
    logic [31:0]   r_fires,   n_fires;
    logic [31:0]   r_last,    n_last;
    logic [PW-1:0] r_pos,     n_pos;

    // sequencer
    rit_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_n,   n_n;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_rd_idx, n_rd_idx;
    logic          r_rd_vld;
    logic [31:0]   r_rd_data;
    logic [SW-1:0] r_sum;
    logic [CW:0]   r_rem;
    logic [BW-1:0] r_bit;
    logic [31:0]   hist_mem [HISTORY_DEPTH];

    rit_pkg::t_out r_res, n_res;
    rit_pkg::t_out r_out, n_out;
    logic          r_ov;

    logic        in_xfer, out_xfer, out_free;
    logic        rd_issue, load_out;
    logic        fire, hist_we;
    logic [31:0] since, since_sel;
    logic [CW-1:0] samp_cl;
    logic [CW:0]   rem_sh;
    logic          rem_ge;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_ov && !i_stall;
    assign out_free = !r_ov || !i_stall;
    assign o_valid  = r_ov;
    assign o_data   = r_out;

    // step update, evaluated at the input transfer
    always_comb begin
        since     = i_data.now_ms - r_ref;
        fire      = (i_data.func == rit_pkg::FUNC_POLL) && r_active && (since >= r_interval);
        n_active  = r_active;
        n_ref     = r_ref;
        n_fires   = r_fires;
        n_last    = r_last;
        n_pos     = r_pos;
        hist_we   = 1'b0;
        since_sel = since;
        case (i_data.func)
            rit_pkg::FUNC_STOP: begin
                n_active = 1'b0;
            end
            rit_pkg::FUNC_START: begin
                n_active  = 1'b1;
                n_ref     = i_data.now_ms;
                since_sel = '0;
            end
            rit_pkg::FUNC_POLL: begin
                if (fire) begin
                    hist_we = 1'b1;
                    n_last  = since;
                    n_ref   = i_data.now_ms;
                    n_fires = r_fires + 32'd1;
                    n_pos   = (r_pos == PW'(HISTORY_DEPTH - 1)) ? '0 : r_pos + PW'(1);
                    if ((r_limit != '0) && (n_fires >= r_limit)) begin
                        n_active = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        n_rd_idx = (n_pos == '0) ? PW'(HISTORY_DEPTH - 1) : n_pos - PW'(1);

        if (r_samples == '0) begin
            samp_cl = CW'(1);
        end else if (32'(r_samples) > 32'(HISTORY_DEPTH)) begin
            samp_cl = CW'(HISTORY_DEPTH);
        end else begin
            samp_cl = CW'(r_samples);
        end
        n_n = (n_fires < 32'(samp_cl)) ? CW'(n_fires) : samp_cl;

        n_res.fired             = fire;
        n_res.interval_measured = n_last;
        n_res.fire_count        = n_fires;
        n_res.running           = n_active;
        n_res.remaining_ms      = '0;
        n_res.average_ms        = '0;
        if (!fire && n_active && (since_sel < r_interval)) begin
            n_res.remaining_ms = r_interval - since_sel;
        end
    end

    // divider step
    always_comb begin
        rem_sh = {r_rem[CW-1:0], r_sum[SW-1]};
        rem_ge = (rem_sh >= {1'b0, r_n});
    end

    // result with the mean filled in
    always_comb begin
        n_out            = r_res;
        n_out.average_ms = (r_n == '0) ? '0 : r_sum[31:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rit_pkg::S_IDLE: begin
                if (in_xfer) n_state = rit_pkg::S_SUM;
            end
            rit_pkg::S_SUM: begin
                if ((r_cnt == r_n) && !r_rd_vld) n_state = rit_pkg::S_DIV;
            end
            rit_pkg::S_DIV: begin
                if (r_bit == BW'(1)) n_state = rit_pkg::S_DONE;
            end
            rit_pkg::S_DONE: begin
                if (out_free) n_state = rit_pkg::S_IDLE;
            end
            default: n_state = rit_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall  = 1'b1;
        rd_issue = 1'b0;
        load_out = 1'b0;
        case (r_state)
            rit_pkg::S_IDLE: o_stall  = 1'b0;
            rit_pkg::S_SUM:  rd_issue = (r_cnt != r_n);
            rit_pkg::S_DONE: load_out = out_free;
            default: begin
            end
        endcase
    end

    // history RAM
    always_ff @(posedge i_clk) begin
        if (in_xfer && hist_we) begin
            hist_mem[r_pos] <= since;
        end
        if (rd_issue) begin
            r_rd_data <= hist_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
            r_limit    <= '0;
            r_samples  <= rit_pkg::SAMPLES_RESET;
            r_active   <= 1'b1;
            r_ref      <= '0;
            r_fires    <= '0;
            r_last     <= '0;
            r_pos      <= '0;
            r_state    <= rit_pkg::S_IDLE;
            r_rd_vld   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rit_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                    rit_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data;
                    rit_pkg::CFG_SAMPLES:  r_samples  <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                r_active <= n_active;
                r_ref    <= n_ref;
                r_fires  <= n_fires;
                r_last   <= n_last;
                r_pos    <= n_pos;
            end
            r_state  <= n_state;
            r_rd_vld <= rd_issue;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (out_xfer) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res    <= n_res;
            r_n      <= n_n;
            r_cnt    <= '0;
            r_rd_idx <= n_rd_idx;
            r_sum    <= '0;
        end
        if (rd_issue) begin
            r_cnt    <= r_cnt + CW'(1);
            r_rd_idx <= (r_rd_idx == '0) ? PW'(HISTORY_DEPTH - 1) : r_rd_idx - PW'(1);
        end
        if (r_rd_vld) begin
            r_sum <= r_sum + SW'(r_rd_data);
        end
        if ((r_state == rit_pkg::S_SUM) && (n_state == rit_pkg::S_DIV)) begin
            r_rem <= '0;
            r_bit <= BW'(SW);
        end
        if (r_state == rit_pkg::S_DIV) begin
            r_rem <= rem_ge ? (rem_sh - {1'b0, r_n}) : rem_sh;
            r_sum <= {r_sum[SW-2:0], rem_ge};
            r_bit <= r_bit - BW'(1);
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    `RIT_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= PW'(HISTORY_DEPTH - 1))
    `RIT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_xfer, r_state == rit_pkg::S_SUM)
    `RIT_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, load_out, o_valid && (r_state == rit_pkg::S_IDLE))
    `RIT_ASSERT_NOW(a_fire_no_remain, i_clk, i_rst_n, o_valid && o_data.fired, o_data.remaining_ms == '0)
    `RIT_ASSERT_NOW(a_div_no_issue, i_clk, i_rst_n, r_state == rit_pkg::S_DIV, !rd_issue && !r_rd_vld)

endmodule

`default_nettype wire
